[hw/rtl/assert_macros.svh]
// Assertion shorthands used by neural_activation_unit.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check on every clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check on every clock edge, reset included.
`define ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[hw/rtl/nau_pkg.sv]
package nau_pkg;

  // Default data format: Q5.10 in 16 bits, 256-segment tanh curve
  localparam int DATA_WIDTH_DEF = 16;
  localparam int FRAC_BITS_DEF  = 10;
  localparam int TABLE_BITS_DEF = 8;

  // Extra fraction bits kept in the tanh curve
  localparam int GUARD = 6;

  // Configuration port
  localparam int ADDR_WIDTH     = 3;
  localparam int APB_DATA_WIDTH = 32;
  localparam int FT_WIDTH       = 3;
  localparam logic [ADDR_WIDTH-3:0] REG_FUNCTION_TYPE = '0;

  // Activation codes
  localparam logic [FT_WIDTH-1:0] FT_LINEAR  = 3'd0;
  localparam logic [FT_WIDTH-1:0] FT_STEP    = 3'd1;
  localparam logic [FT_WIDTH-1:0] FT_RELU    = 3'd2;
  localparam logic [FT_WIDTH-1:0] FT_LEAKY   = 3'd3;
  localparam logic [FT_WIDTH-1:0] FT_SIGMOID = 3'd4;
  localparam logic [FT_WIDTH-1:0] FT_TANH    = 3'd5;

  // Divide by ten: halve, then multiply by the reciprocal of five
  localparam logic [31:0] RECIP_5     = 32'hCCCC_CCCD;
  localparam int          RECIP_SHIFT = 34;

  // One in the Q2.62 format used while building the curve
  localparam logic [63:0] Q62_ONE = 64'h4000_0000_0000_0000;

  // Q2.62 product, truncated
  function automatic logic [63:0] mul_q62(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    return p[125:62];
  endfunction

  // Restoring long division, used only while building constants
  function automatic logic [63:0] udiv64(input logic [63:0] a, input logic [63:0] b);
    logic [64:0] rem;
    logic [63:0] q;
    rem = '0;
    q   = '0;
    for (int i = 63; i >= 0; i--) begin
      rem = {rem[63:0], a[i]};
      if (rem >= {1'b0, b}) begin
        rem  = rem - {1'b0, b};
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  // Rounded num / den with the given number of fraction bits, num below den
  function automatic logic [63:0] div_frac(input logic [63:0] num, input logic [63:0] den,
                                           input int steps);
    logic [63:0] r;
    logic [63:0] q;
    r = num;
    q = '0;
    for (int i = 0; i < steps; i++) begin
      r = r << 1;
      q = q << 1;
      if (r >= den) begin
        r    = r - den;
        q[0] = 1'b1;
      end
    end
    if ((r << 1) >= den) q = q + 64'd1;
    return q;
  endfunction

  // exp(-2^(4-tb)) in Q2.62 from its power series
  function automatic logic [63:0] tanh_base(input int tb);
    logic [63:0] pos;
    logic [63:0] neg;
    logic [63:0] term;
    pos  = Q62_ONE;
    neg  = '0;
    term = Q62_ONE;
    for (int n = 1; n <= 40; n++) begin
      term = udiv64(term >> (tb - 4), 64'(n));
      if (n[0]) neg = neg + term;
      else pos = pos + term;
    end
    return pos - neg;
  endfunction

endpackage

[hw/rtl/nau_in_if.sv]
interface nau_in_if import nau_pkg::*; #(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) ();

  logic                         valid;
  logic                         ready;
  logic                         action;
  logic signed [DATA_WIDTH-1:0] x_value;

  modport source (output valid, output action, output x_value, input ready);
  modport sink (input valid, input action, input x_value, output ready);

endinterface

[hw/rtl/nau_out_if.sv]
interface nau_out_if import nau_pkg::*; #(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) ();

  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] y_value;

  modport source (output valid, output y_value, input ready);
  modport sink (input valid, input y_value, output ready);

endinterface

[hw/rtl/neural_activation_unit.sv]
// Elementwise activation unit. Each request carries one signed fixed-point value
// (DATA_WIDTH bits, FRAC_BITS fraction bits, Q5.10 by default) and an action bit
// that picks the activation (0) or its derivative (1); the result has the same
// format. The activation is set by register function_type at byte address 0:
// linear, binary step, ReLU, leaky ReLU (slope 0.1, rounded to nearest),
// sigmoid or tanh; codes 6 and 7 return zero. Sigmoid and tanh read one shared,
// linearly interpolated tanh curve held in two constant ROM banks (even and odd
// segment ends), with sigmoid(x) = (1 + tanh(x/2)) / 2; both saturate for large
// magnitudes. The unit is an 8-stage pipeline (magnitude, registered curve ROM
// read, segment select, interpolation multiply, rounding, scaling, derivative
// multiply, output register): it takes one request per clock while the output
// is ready, and results leave in request order. A stall at the output fills
// empty stages first, so requests are still taken until every stage holds one.
// No clearing pass is needed after reset. Write the register only while no
// request is in flight.
`include "assert_macros.svh"

module neural_activation_unit import nau_pkg::*; #(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF,
  parameter int TABLE_BITS = TABLE_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [ADDR_WIDTH-1:0]     paddr,
  input  logic [APB_DATA_WIDTH-1:0] pwdata,
  output logic [APB_DATA_WIDTH-1:0] prdata,
  output logic                      pready,
  nau_in_if.sink                    sample,
  nau_out_if.source                 result
);

  localparam int DW = DATA_WIDTH;
  localparam int FB = FRAC_BITS;
  localparam int TB = TABLE_BITS;
  localparam int G  = GUARD;
  localparam int NS = 8;

  // Curve entries and segment addressing
  localparam int TW      = FB + G + 1;
  localparam int TAB_LEN = (1 << TB) + 1;
  localparam int EVEN_N  = (1 << (TB - 1)) + 1;
  localparam int ODD_N   = 1 << (TB - 1);
  localparam int HALF_TB = 1 << (TB - 1);
  localparam int SH_T    = FB + 3 - TB;
  localparam int PAD     = (SH_T >= 1) ? 0 : 1 - SH_T;
  localparam int SHP_T   = SH_T + PAD;
  localparam int SHP_S   = SHP_T + 1;
  localparam int FRW     = SHP_S;
  localparam int AW      = DW + PAD + TB;
  localparam int PW      = TW + FRW;

  // Result paths
  localparam int MW  = FB + 1;
  localparam int SW  = TW + 2;
  localparam int DPW = 2 * MW;
  localparam int QW  = DW - 2;
  localparam int LPW = DW + 32;
  localparam int YW  = ((DW > FB + 2) ? DW : FB + 2) + 1;

  localparam logic [FRW-1:0] FR_MASK_T = {FRW{1'b1}} >> 1;
  localparam logic [PW:0]    RND_T     = (PW + 1)'(1) << (SHP_T - 1);
  localparam logic [PW:0]    RND_S     = (PW + 1)'(1) << (SHP_S - 1);
  localparam logic [TW:0]    M_RND     = (TW + 1)'(1) << (G - 1);
  localparam logic [SW-1:0]  SIG_BIAS  = (SW'(1) << (FB + G)) + (SW'(1) << G);
  localparam logic [MW-1:0]  ONE_M     = MW'(1) << FB;
  localparam logic [DPW:0]   HALF_R    = (DPW + 1)'(1) << (FB - 1);

  localparam logic signed [YW-1:0] ONE_Y  = YW'(1) << FB;
  localparam logic signed [YW-1:0] LEAK_Y = YW'(((1 << FRAC_BITS) + 5) / 10);
  localparam logic signed [YW-1:0] Y_MAX  = {{(YW - DW + 1){1'b0}}, {(DW - 1){1'b1}}};
  localparam logic signed [YW-1:0] Y_MIN  = {{(YW - DW + 1){1'b1}}, {(DW - 1){1'b0}}};

  typedef logic [TW-1:0] even_rom_t [EVEN_N];
  typedef logic [TW-1:0] odd_rom_t [ODD_N];

  typedef struct packed {
    logic                 deriv;
    logic                 neg;
    logic signed [DW-1:0] x;
  } item_t;

  // Even-numbered points of the tanh curve over [0, 8]
  function automatic even_rom_t build_even_rom();
    even_rom_t   rom;
    logic [63:0] base;
    logic [63:0] e;
    base = tanh_base(TABLE_BITS);
    e    = Q62_ONE;
    for (int n = 0; n < TAB_LEN; n++) begin
      if (!n[0]) rom[n >> 1] = TW'(div_frac(Q62_ONE - e, Q62_ONE + e, FB + G));
      e = mul_q62(e, base);
    end
    return rom;
  endfunction

  // Odd-numbered points of the same curve
  function automatic odd_rom_t build_odd_rom();
    odd_rom_t    rom;
    logic [63:0] base;
    logic [63:0] e;
    base = tanh_base(TABLE_BITS);
    e    = Q62_ONE;
    for (int n = 0; n < TAB_LEN; n++) begin
      if (n[0]) rom[n >> 1] = TW'(div_frac(Q62_ONE - e, Q62_ONE + e, FB + G));
      e = mul_q62(e, base);
    end
    return rom;
  endfunction

  localparam even_rom_t EVEN_ROM = build_even_rom();
  localparam odd_rom_t  ODD_ROM  = build_odd_rom();

  logic [FT_WIDTH-1:0]     function_type;
  logic [ADDR_WIDTH-3:0]   reg_word;
  logic                    apb_wr;
  logic                    is_sig;

  logic [NS-1:0]           vld;
  logic [NS-1:0]           adv;
  item_t                   s_item [NS-1];
  item_t                   item_in;

  logic [DW-1:0]           mag_in;
  logic [DW-1:0]           s1_mag;
  logic [AW-1:0]           a_sc;
  logic [AW-1:0]           idx_full;
  logic [TB-1:0]           idx;
  logic                    sat;
  logic [FRW-1:0]          fr_raw;
  logic [TB-1:0]           even_addr;
  logic [TB-2:0]           odd_addr;
  logic [DW:0]             lk_sum;

  logic                    s2_sat;
  logic                    s2_odd;
  logic [FRW-1:0]          s2_fr;
  logic [TW-1:0]           s2_even_q;
  logic [TW-1:0]           s2_odd_q;
  logic [DW-1:0]           s2_lk_n;

  logic [TW-1:0]           t0_sel;
  logic [TW-1:0]           t1_sel;
  logic [TW-1:0]           s3_t0;
  logic [TW-1:0]           s3_diff;
  logic [FRW-1:0]          s3_fr;
  logic [LPW-1:0]          s3_lk_prod;

  logic [TW-1:0]           s4_t0;
  logic [PW-1:0]           s4_prod;
  logic [QW-1:0]           s4_lk_q;

  logic [PW:0]             rs_t;
  logic [PW:0]             rs_s;
  logic [PW:0]             interp;
  logic [TW-1:0]           l_next;
  logic [TW-1:0]           s5_l;
  logic [QW-1:0]           s5_lk_q;

  logic [TW:0]             m_sum;
  logic [SW-1:0]           s_sum;
  logic [MW-1:0]           mq_next;
  logic [MW-1:0]           s6_mq;
  logic [QW-1:0]           s6_lk_q;

  logic [MW-1:0]           opb;
  logic [DPW-1:0]          s7_dprod;
  logic [MW-1:0]           s7_mq;
  logic [QW-1:0]           s7_lk_q;

  logic [DPW:0]            r_sum;
  logic signed [YW-1:0]    x_y;
  logic signed [YW-1:0]    mq_y;
  logic signed [YW-1:0]    r_y;
  logic signed [YW-1:0]    q_y;
  logic signed [YW-1:0]    y_full;
  logic [DW-1:0]           y_next;
  logic [DW-1:0]           y_reg;

  // Configuration port: writes complete in the access phase
  assign pready   = 1'b1;
  assign reg_word = paddr[ADDR_WIDTH-1:2];
  assign apb_wr   = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      function_type <= FT_LINEAR;
    end else if (apb_wr && (reg_word == REG_FUNCTION_TYPE)) begin
      function_type <= pwdata[FT_WIDTH-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    unique case (reg_word)
      REG_FUNCTION_TYPE: prdata = APB_DATA_WIDTH'(function_type);
      default:           prdata = '0;
    endcase
  end

  assign is_sig = (function_type == FT_SIGMOID);

  // Advance a stage when it is empty or the next one advances
  always_comb begin
    adv[NS-1] = !vld[NS-1] || result.ready;
    for (int k = NS - 2; k >= 0; k--) begin
      adv[k] = !vld[k] || adv[k+1];
    end
  end

  assign sample.ready = adv[0];
  assign result.valid = vld[NS-1];
  assign result.y_value = y_reg;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (adv[0]) vld[0] <= sample.valid;
      for (int k = 1; k < NS; k++) begin
        if (adv[k]) vld[k] <= vld[k-1];
      end
    end
  end

  // Carry sign, value and action alongside the datapath
  assign item_in.deriv = sample.action;
  assign item_in.neg   = sample.x_value[DW-1];
  assign item_in.x     = sample.x_value;
  assign mag_in = item_in.neg ? (~sample.x_value + 1'b1) : sample.x_value;

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      s_item[0] <= item_in;
      s1_mag    <= mag_in;
    end
    for (int k = 1; k < NS - 1; k++) begin
      if (adv[k]) s_item[k] <= s_item[k-1];
    end
  end

  // Stage 2: segment index, fraction and registered curve ROM read
  assign a_sc     = AW'(s1_mag) << PAD;
  assign idx_full = is_sig ? (a_sc >> SHP_S) : (a_sc >> SHP_T);
  assign sat      = (idx_full >> TB) != '0;
  assign idx      = idx_full[TB-1:0];
  assign fr_raw   = is_sig ? FRW'(a_sc) : (FRW'(a_sc) & FR_MASK_T);
  assign even_addr = sat ? TB'(HALF_TB) : (TB'(idx[TB-1:1]) + TB'(idx[0]));
  assign odd_addr  = idx[TB-1:1];
  assign lk_sum    = {1'b0, s1_mag} + (DW + 1)'(5);

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      s2_sat    <= sat;
      s2_odd    <= idx[0];
      s2_fr     <= sat ? '0 : fr_raw;
      s2_even_q <= EVEN_ROM[even_addr];
      s2_odd_q  <= ODD_ROM[odd_addr];
      s2_lk_n   <= lk_sum[DW:1];
    end
  end

  // Stage 3: order the segment ends, take the rise, scale the leaky term
  assign t0_sel = (s2_odd && !s2_sat) ? s2_odd_q : s2_even_q;
  assign t1_sel = (s2_sat || s2_odd) ? s2_even_q : s2_odd_q;

  always_ff @(posedge clk) begin
    if (adv[2]) begin
      s3_t0      <= t0_sel;
      s3_diff    <= t1_sel - t0_sel;
      s3_fr      <= s2_fr;
      s3_lk_prod <= LPW'(s2_lk_n) * LPW'(RECIP_5);
    end
  end

  // Stage 4: interpolation product
  always_ff @(posedge clk) begin
    if (adv[3]) begin
      s4_t0   <= s3_t0;
      s4_prod <= PW'(s3_diff) * PW'(s3_fr);
      s4_lk_q <= s3_lk_prod[LPW-1:RECIP_SHIFT];
    end
  end

  // Stage 5: round the product and add the segment start
  assign rs_t   = (PW + 1)'(s4_prod) + RND_T;
  assign rs_s   = (PW + 1)'(s4_prod) + RND_S;
  assign interp = is_sig ? (rs_s >> SHP_S) : (rs_t >> SHP_T);
  assign l_next = s4_t0 + TW'(interp);

  always_ff @(posedge clk) begin
    if (adv[4]) begin
      s5_l    <= l_next;
      s5_lk_q <= s4_lk_q;
    end
  end

  // Stage 6: drop guard bits, or fold tanh into sigmoid
  assign m_sum = (TW + 1)'(s5_l) + M_RND;
  assign s_sum = s_item[4].neg ? (SIG_BIAS - SW'(s5_l)) : (SIG_BIAS + SW'(s5_l));
  assign mq_next = is_sig ? MW'(s_sum >> (G + 1)) : MW'(m_sum >> G);

  always_ff @(posedge clk) begin
    if (adv[5]) begin
      s6_mq   <= mq_next;
      s6_lk_q <= s5_lk_q;
    end
  end

  // Stage 7: derivative product, t*t or s*(1-s)
  assign opb = is_sig ? (ONE_M - s6_mq) : s6_mq;

  always_ff @(posedge clk) begin
    if (adv[6]) begin
      s7_dprod <= DPW'(s6_mq) * DPW'(opb);
      s7_mq    <= s6_mq;
      s7_lk_q  <= s6_lk_q;
    end
  end

  // Stage 8: pick the result and clamp it to the output range
  assign r_sum = (DPW + 1)'(s7_dprod) + HALF_R;
  assign r_y   = YW'(MW'(r_sum >> FB));
  assign x_y   = YW'(s_item[6].x);
  assign mq_y  = YW'(s7_mq);
  assign q_y   = YW'(s7_lk_q);

  always_comb begin
    y_full = '0;
    unique case (function_type)
      FT_LINEAR:  y_full = s_item[6].deriv ? ONE_Y : x_y;
      FT_STEP:    y_full = (s_item[6].deriv || s_item[6].neg) ? '0 : ONE_Y;
      FT_RELU:    y_full = s_item[6].neg ? '0 : (s_item[6].deriv ? ONE_Y : x_y);
      FT_LEAKY: begin
        if (!s_item[6].neg) y_full = s_item[6].deriv ? ONE_Y : x_y;
        else y_full = s_item[6].deriv ? LEAK_Y : -q_y;
      end
      FT_SIGMOID: y_full = s_item[6].deriv ? r_y : mq_y;
      FT_TANH: begin
        if (s_item[6].deriv) y_full = ONE_Y - r_y;
        else y_full = s_item[6].neg ? -mq_y : mq_y;
      end
      default:    y_full = '0;
    endcase
  end

  always_comb begin
    if (y_full > Y_MAX) y_next = Y_MAX[DW-1:0];
    else if (y_full < Y_MIN) y_next = Y_MIN[DW-1:0];
    else y_next = y_full[DW-1:0];
  end

  always_ff @(posedge clk) begin
    if (adv[7]) y_reg <= y_next;
  end

  `ASSERT_RST(a_reset_empty, rst |=> (vld == '0), "pipeline holds a request after reset")
  `ASSERT_CLK(a_ready_full, !sample.ready |-> (&vld), "input held off with a free stage")
  `ASSERT_CLK(a_hold_lookup, (vld[2] && !adv[2]) |=> (vld[2] && $stable(s3_t0) && $stable(s3_diff)), "stalled segment stage changed")

endmodule
